>>> hw/rtl/double_ended_queue_with_search_defines.svh
// assertion macros shared by the checker
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while in reset
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int OCC_W    = 5;

    // position reported when nothing was found or no position applies (-1)
    localparam logic [POS_W-1:0] NO_POSITION = {POS_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_HEAD  = 3'd0,
        K_PUSH_TAIL  = 3'd1,
        K_POP_HEAD   = 3'd2,
        K_POP_TAIL   = 3'd3,
        K_FIND       = 3'd4,
        K_REMOVE_ALL = 3'd5,
        K_CLEAR      = 3'd6
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // ring slot at a given offset from the head, one compare and subtract
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] offset);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(offset);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/double_ended_queue_with_search.sv
`default_nettype none

// Bounded double-ended queue of DEPTH signed words kept as a ring in a small
// memory with one write port and one registered read port. A request is a
// transaction taken when start is high and busy is low; every request gives
// exactly one result, shown for a single cycle with o_valid high, and the
// receiver cannot stall it, so results must be captured when they appear.
// Timing: push, clear, an unused kind, a pop of an empty queue and a find or
// remove-all on an empty queue answer in the cycle after acceptance without
// raising busy. A pop reads the entry through the registered read port and
// answers from state S_POP. Find and remove-all walk the entries from the head
// through one shared comparator at one entry a cycle: find stops at the first
// match or after the last entry, remove-all always walks every entry. The next
// request may be accepted in the cycle its predecessor's result is on the
// ports.
module double_ended_queue_with_search (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [deq_pkg::KIND_W-1:0]    i_kind,
    input  wire logic signed [deq_pkg::VALUE_W-1:0] i_data_value,
    output logic                               o_valid,
    output logic [deq_pkg::STATUS_W-1:0]       o_status,
    output logic signed [deq_pkg::VALUE_W-1:0] o_result_value,
    output logic signed [deq_pkg::POS_W-1:0]   o_position,
    output logic [deq_pkg::OCC_W-1:0]          o_occupancy
);
    import deq_pkg::*;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    // entry memory
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // control state
    t_state        r_state,  n_state;
    logic [AW-1:0] r_head,   n_head;
    logic [CW-1:0] r_count,  n_count;
    logic          r_valid,  n_valid;

    // per-request working registers
    t_kind                 r_kind, n_kind;
    logic [DATA_WIDTH-1:0] r_v,    n_v;
    logic [CW-1:0]         r_idx,  n_idx;
    logic [CW-1:0]         r_kept, n_kept;

    // result registers
    t_status               r_status,   n_status;
    logic [VALUE_W-1:0]    r_result,   n_result;
    logic [POS_W-1:0]      r_position, n_position;
    logic [OCC_W-1:0]      r_occ,      n_occ;

    // memory port controls
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic [AW-1:0]         w_rd_addr;

    logic                  w_accept;
    logic [DATA_WIDTH-1:0] w_in_v;
    logic                  w_match;
    logic                  w_last;
    logic [CW-1:0]         w_kept_inc;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    // only the low DATA_WIDTH bits take part in storing and comparing
    assign w_in_v   = DATA_WIDTH'($unsigned(i_data_value));

    // shared comparator of the walk, fed by the registered read data
    assign w_match    = (r_rdata == r_v);
    assign w_last     = (r_idx == r_count - CW'(1));
    assign w_kept_inc = w_match ? r_kept : r_kept + CW'(1);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_kind     = r_kind;
        n_v        = r_v;
        n_idx      = r_idx;
        n_kept     = r_kept;
        n_status   = r_status;
        n_result   = r_result;
        n_position = r_position;
        n_occ      = r_occ;

        w_wr_en    = 1'b0;
        w_wr_addr  = slot_of(r_head, r_kept);
        w_wr_data  = r_rdata;
        // during the walk, fetch the entry after the one being compared
        w_rd_addr  = slot_of(r_head, r_idx + CW'(1));

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind     = t_kind'(i_kind);
                    n_v        = w_in_v;
                    n_idx      = '0;
                    n_kept     = '0;
                    // default: immediate answer, fields without meaning
                    n_valid    = 1'b1;
                    n_status   = ST_OK;
                    n_result   = '0;
                    n_position = NO_POSITION;
                    n_occ      = OCC_W'(r_count);
                    unique case (t_kind'(i_kind))
                        K_PUSH_HEAD: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_head    = (r_head == '0) ? AW'(DEPTH - 1)
                                                           : r_head - AW'(1);
                                w_wr_en   = 1'b1;
                                w_wr_addr = n_head;
                                w_wr_data = w_in_v;
                                n_count   = r_count + CW'(1);
                                n_occ     = OCC_W'(n_count);
                            end
                        end
                        K_PUSH_TAIL: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = slot_of(r_head, r_count);
                                w_wr_data = w_in_v;
                                n_count   = r_count + CW'(1);
                                n_occ     = OCC_W'(n_count);
                            end
                        end
                        K_POP_HEAD, K_POP_TAIL: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // read the entry now, answer from S_POP
                                n_valid   = 1'b0;
                                n_state   = S_POP;
                                w_rd_addr = (t_kind'(i_kind) == K_POP_HEAD)
                                          ? r_head
                                          : slot_of(r_head, r_count - CW'(1));
                            end
                        end
                        K_FIND, K_REMOVE_ALL: begin
                            if (r_count == '0) begin
                                // nothing to walk over
                                if (t_kind'(i_kind) == K_FIND) begin
                                    n_status = ST_NOT_FOUND;
                                end
                            end else begin
                                n_valid   = 1'b0;
                                n_state   = S_SCAN;
                                w_rd_addr = r_head;
                            end
                        end
                        K_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                            n_occ   = '0;
                        end
                        default: begin
                            // unused kind: no change
                        end
                    endcase
                end
            end

            S_POP: begin
                if (r_kind == K_POP_HEAD) begin
                    n_head = slot_of(r_head, CW'(1));
                end
                n_count    = r_count - CW'(1);
                n_valid    = 1'b1;
                n_status   = ST_OK;
                n_result   = VALUE_W'(r_rdata);
                n_position = NO_POSITION;
                n_occ      = OCC_W'(n_count);
                n_state    = S_IDLE;
            end

            S_SCAN: begin
                n_result = '0;
                if (r_kind == K_FIND) begin
                    if (w_match || w_last) begin
                        n_valid    = 1'b1;
                        n_status   = w_match ? ST_OK : ST_NOT_FOUND;
                        n_position = w_match ? POS_W'(r_idx) : NO_POSITION;
                        n_occ      = OCC_W'(r_count);
                        n_state    = S_IDLE;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end else begin
                    // compact survivors towards the head, order kept
                    if (!w_match) begin
                        w_wr_en = 1'b1;
                    end
                    n_kept = w_kept_inc;
                    if (w_last) begin
                        n_count    = w_kept_inc;
                        n_valid    = 1'b1;
                        n_status   = ST_OK;
                        n_position = NO_POSITION;
                        n_occ      = OCC_W'(w_kept_inc);
                        n_state    = S_IDLE;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // working and result registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_v        <= n_v;
        r_idx      <= n_idx;
        r_kept     <= n_kept;
        r_status   <= n_status;
        r_result   <= n_result;
        r_position <= n_position;
        r_occ      <= n_occ;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_result_value = r_result;
    assign o_position     = r_position;
    assign o_occupancy    = r_occ;

endmodule

`default_nettype wire

>>> hw/rtl/deq_checker.sv
`default_nettype none

`include "double_ended_queue_with_search_defines.svh"

module deq_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic                            o_valid,
    input wire logic [deq_pkg::STATUS_W-1:0]    o_status,
    input wire logic [deq_pkg::POS_W-1:0]       o_position,
    input wire logic [deq_pkg::OCC_W-1:0]       o_occupancy
);
    import deq_pkg::*;

    // an accepted transaction is either answered next cycle or keeps busy high
    `DEQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_valid, "accept lost")

    // a result only follows an accepted transaction or a busy cycle
    `DEQ_ASSERT_SAME(a_valid_has_cause, o_valid, $past(start && !busy) || $past(busy), "stray result")

    // a push is only refused when the store is full
    `DEQ_ASSERT_SAME(a_full_occupancy, o_valid && o_status == ST_FULL, o_occupancy == OCC_W'(DEPTH), "full flagged below depth")

    // a found position is reported only with ok and lies inside the queue
    `DEQ_ASSERT_SAME(a_position_ok, o_valid && o_position != NO_POSITION, o_status == ST_OK && o_position < o_occupancy, "bad position")

endmodule

bind double_ended_queue_with_search deq_checker u_deq_checker (.*);

`default_nettype wire
